### hw/rtl/alp_pkg.sv
// alp_pkg: shared types and codes for the address lease pool.
// Holds request modes, reply codes, FSM states and the controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps

package alp_pkg;

	localparam int ADDR_W    = 32;
	localparam int TIME_W    = 32;
	localparam int LEASE_W   = 31;
	localparam int COUNT_W   = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	typedef logic [2:0] mode_t;
	localparam mode_t MODE_ALLOC   = 3'd0;
	localparam mode_t MODE_RENEW   = 3'd1;
	localparam mode_t MODE_RELEASE = 3'd2;
	localparam mode_t MODE_DECLINE = 3'd3;
	localparam mode_t MODE_SWEEP   = 3'd4;

	typedef logic [1:0] reply_t;
	localparam reply_t REPLY_NONE  = 2'd0;
	localparam reply_t REPLY_OFFER = 2'd1;
	localparam reply_t REPLY_ACK   = 2'd2;
	localparam reply_t REPLY_NAK   = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_BASE_ADDRESS  = 1'b0;
	localparam cfg_idx_t CFG_LEASE_SECONDS = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_RENEW,
		ST_FINISH
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic capture;
		logic clr_step;
		logic scan_start;
		logic scan_step;
		logic lookup;
		logic renew_chk;
		logic entry_write;
		logic set_nak;
		logic out_load;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		mode_t mode;
		logic  hit;
		logic  scan_found;
		logic  scan_done;
		logic  clear_last;
		logic  out_free;
	} sts_t;

endpackage

### hw/rtl/alp_ctrl.sv
// alp_ctrl: request sequencer for the address lease pool.
// Depends on alp_pkg for state, command and status types.
`timescale 1ns / 1ps

module alp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  alp_pkg::sts_t sts,
	output alp_pkg::cmd_t cmd
);

	alp_pkg::state_t state_q;
	alp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			alp_pkg::ST_CLEAR: begin
				if (sts.clear_last) state_d = alp_pkg::ST_IDLE;
			end
			alp_pkg::ST_IDLE: begin
				if (in_valid) state_d = alp_pkg::ST_DISPATCH;
			end
			alp_pkg::ST_DISPATCH: begin
				case (sts.mode)
					alp_pkg::MODE_ALLOC,
					alp_pkg::MODE_SWEEP: state_d = alp_pkg::ST_SCAN;
					alp_pkg::MODE_RENEW: begin
						state_d = sts.hit ? alp_pkg::ST_RENEW : alp_pkg::ST_FINISH;
					end
					default: state_d = alp_pkg::ST_FINISH;
				endcase
			end
			alp_pkg::ST_SCAN: begin
				if (sts.scan_found || sts.scan_done) state_d = alp_pkg::ST_FINISH;
			end
			alp_pkg::ST_RENEW: begin
				state_d = alp_pkg::ST_FINISH;
			end
			alp_pkg::ST_FINISH: begin
				if (sts.out_free) state_d = alp_pkg::ST_IDLE;
			end
			default: state_d = alp_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			alp_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			alp_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			alp_pkg::ST_DISPATCH: begin
				case (sts.mode)
					alp_pkg::MODE_ALLOC,
					alp_pkg::MODE_SWEEP: cmd.scan_start = 1'b1;
					alp_pkg::MODE_RENEW: begin
						cmd.lookup  = sts.hit;
						cmd.set_nak = !sts.hit;
					end
					alp_pkg::MODE_RELEASE,
					alp_pkg::MODE_DECLINE: cmd.entry_write = sts.hit;
					default: cmd = '0;
				endcase
			end
			alp_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
			alp_pkg::ST_RENEW:  cmd.renew_chk = 1'b1;
			alp_pkg::ST_FINISH: cmd.out_load  = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

### hw/rtl/alp_dp.sv
// alp_dp: datapath of the address lease pool.
// Holds the entry memories, config registers, scan pipeline and result registers.
// Depends on alp_pkg.
`timescale 1ns / 1ps

module alp_dp #(
	parameter int POOL_SIZE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  alp_pkg::cmd_t                 cmd,
	output alp_pkg::sts_t                 sts,
	input  logic [2:0]                    mode,
	input  logic [alp_pkg::ADDR_W-1:0]    address,
	input  logic [alp_pkg::TIME_W-1:0]    now_seconds,
	input  logic                          cfg_valid,
	input  logic [alp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [alp_pkg::ADDR_W-1:0]    cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    reply,
	output logic [alp_pkg::ADDR_W-1:0]    granted_address,
	output logic [alp_pkg::COUNT_W-1:0]   expired_count
);

	localparam int IDX_W   = $clog2(POOL_SIZE);
	localparam int CNT_W   = IDX_W + 1;
	localparam int LMEM_W  = alp_pkg::TIME_W + alp_pkg::LEASE_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_SIZE - 1);

	// Config registers
	logic [alp_pkg::ADDR_W-1:0]  base_q;
	logic [alp_pkg::LEASE_W-1:0] lease_sec_q;

	// Captured request
	alp_pkg::mode_t              mode_q;
	logic [alp_pkg::ADDR_W-1:0]  addr_q;
	logic [alp_pkg::TIME_W-1:0]  now_q;

	// Scan state
	logic [IDX_W-1:0]            ptr_q;
	logic [IDX_W-1:0]            iss_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [IDX_W-1:0]            clr_q;
	logic                        vld_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [alp_pkg::COUNT_W-1:0] count_q;

	// Pending result
	alp_pkg::reply_t             res_reply_q;
	logic [alp_pkg::ADDR_W-1:0]  res_granted_q;

	// Output register
	logic                        out_valid_q;
	alp_pkg::reply_t             reply_q;
	logic [alp_pkg::ADDR_W-1:0]  granted_q;
	logic [alp_pkg::COUNT_W-1:0] expired_q;

	// Memories
	logic                        free_mem [POOL_SIZE];
	logic [LMEM_W-1:0]           lease_mem [POOL_SIZE];
	logic                        free_rd_q;
	logic [LMEM_W-1:0]           lease_rd_q;

	// Memory ports
	logic                        rd_en;
	logic [IDX_W-1:0]            rd_idx;
	logic                        fw_en;
	logic [IDX_W-1:0]            fw_idx;
	logic                        fw_data;
	logic                        lw_en;
	logic [IDX_W-1:0]            lw_idx;
	logic [LMEM_W-1:0]           lw_data;

	logic [alp_pkg::ADDR_W-1:0]  off;
	logic                        hit;
	logic [IDX_W-1:0]            off_idx;
	logic                        issuing;
	logic                        is_alloc;
	logic                        found;
	logic                        expired;
	logic [alp_pkg::TIME_W-1:0]  elapsed;

	assign off      = addr_q - base_q;
	assign hit      = off < alp_pkg::ADDR_W'(POOL_SIZE);
	assign off_idx  = off[IDX_W-1:0];
	assign issuing  = cnt_q < CNT_W'(POOL_SIZE);
	assign is_alloc = mode_q == alp_pkg::MODE_ALLOC;
	assign found    = cmd.scan_step && vld_s1 && is_alloc && free_rd_q;
	assign elapsed  = now_q - lease_rd_q[LMEM_W-1 -: alp_pkg::TIME_W];
	assign expired  = !free_rd_q &&
	                  (elapsed >= {1'b0, lease_rd_q[alp_pkg::LEASE_W-1:0]});

	always_comb begin
		rd_en   = 1'b0;
		rd_idx  = iss_q;
		fw_en   = 1'b0;
		fw_idx  = idx_s1;
		fw_data = 1'b0;
		lw_en   = 1'b0;
		lw_idx  = idx_s1;
		lw_data = {now_q, lease_sec_q};
		if (cmd.clr_step) begin
			fw_en   = 1'b1;
			fw_idx  = clr_q;
			fw_data = 1'b1;
			lw_en   = 1'b1;
			lw_idx  = clr_q;
			lw_data = '0;
		end
		if (cmd.scan_step) begin
			rd_en = issuing;
			if (vld_s1) begin
				if (is_alloc) begin
					fw_en = free_rd_q;
					lw_en = free_rd_q;
				end else begin
					fw_en   = expired;
					fw_data = 1'b1;
				end
			end
		end
		if (cmd.lookup) begin
			rd_en  = 1'b1;
			rd_idx = off_idx;
		end
		if (cmd.entry_write) begin
			fw_en   = 1'b1;
			fw_idx  = off_idx;
			fw_data = mode_q == alp_pkg::MODE_RELEASE;
		end
		if (cmd.renew_chk) begin
			lw_en  = !free_rd_q;
			lw_idx = off_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (fw_en) free_mem[fw_idx] <= fw_data;
		if (rd_en) free_rd_q <= free_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (lw_en) lease_mem[lw_idx] <= lw_data;
		if (rd_en) lease_rd_q <= lease_mem[rd_idx];
	end

	// Captured request, pending result and output data; no reset needed
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q        <= mode;
			addr_q        <= address;
			now_q         <= now_seconds;
			res_reply_q   <= alp_pkg::REPLY_NONE;
			res_granted_q <= '0;
		end
		if (cmd.set_nak) res_reply_q <= alp_pkg::REPLY_NAK;
		if (cmd.scan_start) begin
			res_reply_q <= is_alloc ? alp_pkg::REPLY_NAK : alp_pkg::REPLY_NONE;
		end
		if (found) begin
			res_reply_q   <= alp_pkg::REPLY_OFFER;
			res_granted_q <= base_q + alp_pkg::ADDR_W'(idx_s1);
		end
		if (cmd.renew_chk) begin
			if (free_rd_q) begin
				res_reply_q <= alp_pkg::REPLY_NAK;
			end else begin
				res_reply_q   <= alp_pkg::REPLY_ACK;
				res_granted_q <= addr_q;
			end
		end
		if (cmd.out_load) begin
			reply_q   <= res_reply_q;
			granted_q <= res_granted_q;
			expired_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= 32'd3232235876;
			lease_sec_q <= 31'd300;
			ptr_q       <= '0;
			iss_q       <= '0;
			cnt_q       <= '0;
			clr_q       <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					alp_pkg::CFG_BASE_ADDRESS:  base_q <= cfg_data;
					alp_pkg::CFG_LEASE_SECONDS: lease_sec_q <= cfg_data[alp_pkg::LEASE_W-1:0];
					default: base_q <= base_q;
				endcase
			end
			if (cmd.clr_step) clr_q <= clr_q + IDX_W'(1);
			if (cmd.capture) count_q <= '0;
			if (cmd.scan_start) begin
				iss_q  <= is_alloc ? ptr_q : '0;
				cnt_q  <= '0;
				vld_s1 <= 1'b0;
			end
			if (cmd.scan_step) begin
				vld_s1 <= issuing;
				idx_s1 <= iss_q;
				if (issuing) begin
					iss_q <= (iss_q == IDX_LAST) ? '0 : iss_q + IDX_W'(1);
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (vld_s1 && !is_alloc && expired && count_q != alp_pkg::COUNT_MAX) begin
					count_q <= count_q + alp_pkg::COUNT_W'(1);
				end
			end
			if (found) ptr_q <= (idx_s1 == IDX_LAST) ? '0 : idx_s1 + IDX_W'(1);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.mode       = mode_q;
	assign sts.hit        = hit;
	assign sts.scan_found = found;
	assign sts.scan_done  = !issuing && !vld_s1;
	assign sts.clear_last = clr_q == IDX_LAST;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign reply           = reply_q;
	assign granted_address = granted_q;
	assign expired_count   = expired_q;

endmodule

### hw/rtl/address_lease_pool_top.sv
// address_lease_pool_top: top level of the address lease pool.
// Instantiates alp_ctrl (sequencer) and alp_dp (memories and datapath); uses alp_pkg.
`timescale 1ns / 1ps

// Pool of POOL_SIZE address leases; entry i stands for base_address + i.
// Each request returns exactly one result: allocate offers the next free
// entry found by a next-fit scan from a rotating pointer (NAK when the pool
// is full), renew restarts the lease of an assigned entry (ACK, else NAK),
// release frees and decline takes an entry by address, and sweep frees all
// taken entries whose lease has run out and reports how many (saturating at
// 127). After reset the block clears the entry memories and takes no
// request in that time; configuration writes are taken at any time but
// must only be issued while the block is idle. Requests are handled one at
// a time. Allocate and sweep walk the entry memories one entry per cycle
// through a one-port registered read; an allocate stops at the first free
// entry, a sweep reads every entry. Renew adds a step to check the entry
// when the address is in the pool. The result sits in an output register,
// so the next request is taken while the previous result still waits to
// be read; a request whose result finds that register still full holds in
// its last step until the register drains.

module address_lease_pool_top #(
	parameter int POOL_SIZE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [31:0] address,
	input  logic [31:0] now_seconds,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  reply,
	output logic [31:0] granted_address,
	output logic [6:0]  expired_count,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	alp_pkg::cmd_t cmd;
	alp_pkg::sts_t sts;

	// Register writes never stall.
	assign cfg_ready = 1'b1;

	// Sequencer: clears the memories, accepts a request, steps through it.
	alp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: entry memories, scan pipeline, config and result registers.
	alp_dp #(
		.POOL_SIZE (POOL_SIZE)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.address         (address),
		.now_seconds     (now_seconds),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.reply           (reply),
		.granted_address (granted_address),
		.expired_count   (expired_count)
	);

endmodule

### test/address_lease_pool_top_tb.sv
// address_lease_pool_top_tb: self-checking bench for the address lease pool top level.
// Runs a directed script, then random request phases under several pool settings, and
// checks each reply against its scripted or predicted answer. Depends on alp_pkg and the top.
`timescale 1ns / 1ps

module address_lease_pool_top_tb;

	localparam int POOL_ENTRIES = 64;
	localparam int SCRIPT_LEN   = 25;
	localparam logic [31:0] RESET_BASE  = 32'hC0A8_0164;
	localparam logic [30:0] RESET_LEASE = 31'd300;

	// Mode codes the block answers with a plain none.
	localparam alp_pkg::mode_t MODE_SPARE_A = 3'd5;
	localparam alp_pkg::mode_t MODE_SPARE_B = 3'd6;
	localparam alp_pkg::mode_t MODE_SPARE_C = 3'd7;

	typedef struct packed {
		alp_pkg::reply_t reply;
		logic [31:0]     granted;
		logic [6:0]      expired;
	} lease_answer_t;

	localparam lease_answer_t QUIET_ANSWER = '{alp_pkg::REPLY_NONE, 32'd0, 7'd0};

	// One scripted request; the answer is used only when typed is set.
	typedef struct packed {
		alp_pkg::mode_t op;
		logic [31:0]    addr;
		logic [31:0]    stamp;
		logic           typed;
		lease_answer_t  want;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  mode;
	logic [31:0] address;
	logic [31:0] now_seconds;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  reply;
	logic [31:0] granted_address;
	logic [6:0]  expired_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;

	// Lease predictor state and its copy of the registers.
	bit          slot_free [POOL_ENTRIES];
	logic [31:0] slot_since [POOL_ENTRIES];
	logic [31:0] slot_span [POOL_ENTRIES];
	int          next_fit;
	logic [31:0] pool_base;
	logic [30:0] lease_len;

	lease_answer_t pending_answers[$];
	lease_answer_t head_answer;
	script_row_t   script [SCRIPT_LEN];

	logic [31:0] wall_clock;
	bit          calm;
	int          stall_left;
	int          mismatches;
	int          accepted;
	int          checked;
	int          offers;
	int          naks;
	int          expired_total;
	int          pool_settings;

	address_lease_pool_top #(
		.POOL_SIZE(POOL_ENTRIES)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.address        (address),
		.now_seconds    (now_seconds),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.reply          (reply),
		.granted_address(granted_address),
		.expired_count  (expired_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one request to the predicted pool and return the reply it earns.
	function automatic lease_answer_t predict_lease_reply(alp_pkg::mode_t op,
			logic [31:0] addr, logic [31:0] stamp);
		lease_answer_t ans;
		logic [31:0]   offset;
		int            slot;
		int            probe;
		bit            found;
		ans    = QUIET_ANSWER;
		offset = addr - pool_base;
		slot   = (offset < POOL_ENTRIES) ? int'(offset) : -1;
		found  = 1'b0;
		case (op)
		alp_pkg::MODE_ALLOC: begin
			ans.reply = alp_pkg::REPLY_NAK;
			for (probe = 0; probe < POOL_ENTRIES; probe++) begin
				slot = (next_fit + probe) % POOL_ENTRIES;
				if (!found && slot_free[slot]) begin
					found            = 1'b1;
					slot_free[slot]  = 1'b0;
					slot_since[slot] = stamp;
					slot_span[slot]  = {1'b0, lease_len};
					next_fit         = (slot + 1) % POOL_ENTRIES;
					ans.reply        = alp_pkg::REPLY_OFFER;
					ans.granted      = pool_base + slot;
				end
			end
		end
		alp_pkg::MODE_RENEW: begin
			if (slot >= 0 && !slot_free[slot]) begin
				slot_since[slot] = stamp;
				slot_span[slot]  = {1'b0, lease_len};
				ans.reply        = alp_pkg::REPLY_ACK;
				ans.granted      = addr;
			end else begin
				ans.reply = alp_pkg::REPLY_NAK;
			end
		end
		alp_pkg::MODE_RELEASE: begin
			if (slot >= 0)
				slot_free[slot] = 1'b1;
		end
		alp_pkg::MODE_DECLINE: begin
			if (slot >= 0)
				slot_free[slot] = 1'b0;
		end
		alp_pkg::MODE_SWEEP: begin
			for (probe = 0; probe < POOL_ENTRIES; probe++) begin
				if (!slot_free[probe] && (stamp - slot_since[probe]) >= slot_span[probe]) begin
					slot_free[probe] = 1'b1;
					if (ans.expired != alp_pkg::COUNT_MAX)
						ans.expired++;
				end
			end
		end
		default: ;
		endcase
		return ans;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t ns: result %0d %s: got 0x%08h, want 0x%08h",
				$time, checked, what, got, want);
	endtask

	// Offer one request; hold it until the block takes it, then log its expected reply.
	task automatic issue_request(alp_pkg::mode_t op, logic [31:0] addr, logic [31:0] stamp,
			bit typed, lease_answer_t typed_answer);
		lease_answer_t predicted;
		int            gap;
		if (!calm && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 72) : $urandom_range(1, 3);
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= op;
		address     <= addr;
		now_seconds <= stamp;
		do @(posedge clk); while (!in_ready);
		predicted = predict_lease_reply(op, addr, stamp);
		pending_answers.push_back(typed ? typed_answer : predicted);
		accepted++;
	endtask

	// Write both registers back to back; only called while the pool is idle.
	task automatic set_pool_config(logic [31:0] base_value, logic [30:0] lease_value);
		cfg_valid <= 1'b1;
		cfg_index <= alp_pkg::CFG_BASE_ADDRESS;
		cfg_data  <= base_value;
		do @(posedge clk); while (!cfg_ready);
		pool_base = base_value;
		// The top bit lies outside the lease register and must be dropped.
		cfg_index <= alp_pkg::CFG_LEASE_SECONDS;
		cfg_data  <= {1'($urandom_range(0, 1)), lease_value};
		do @(posedge clk); while (!cfg_ready);
		lease_len = lease_value;
		cfg_valid <= 1'b0;
		pool_settings++;
		repeat (2) @(posedge clk);
	endtask

	// Drop the request valid, wait out every pending reply, then let the block go idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (POOL_ENTRIES + 8) @(posedge clk);
	endtask

	// Mostly pool addresses, some just outside either end, some anywhere.
	function automatic logic [31:0] pick_address();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return pool_base + $urandom_range(0, POOL_ENTRIES - 1);
		if (roll < 84)
			return pool_base - 1;
		if (roll < 88)
			return pool_base + POOL_ENTRIES;
		return $urandom();
	endfunction

	// Fill the pool first, then switch at random between allocate-heavy and mixed stretches.
	task automatic run_random_phase(int quota, int stride, bit jumpy);
		int             counted;
		int             seen;
		int             roll;
		bit             alloc_heavy;
		alp_pkg::mode_t op;
		counted     = 0;
		seen        = 0;
		alloc_heavy = 1'b0;
		while (counted < quota) begin
			if (seen % 40 == 39)
				alloc_heavy = ($urandom_range(0, 2) == 0);
			roll = $urandom_range(0, 99);
			if (counted < POOL_ENTRIES + 4)
				op = alp_pkg::MODE_ALLOC;
			else if (alloc_heavy)
				op = (roll < 80) ? alp_pkg::MODE_ALLOC :
					(roll < 88) ? alp_pkg::MODE_RENEW :
					(roll < 92) ? alp_pkg::MODE_RELEASE :
					(roll < 96) ? alp_pkg::MODE_SWEEP :
					(roll < 98) ? alp_pkg::MODE_DECLINE :
					alp_pkg::mode_t'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
			else
				op = (roll < 30) ? alp_pkg::MODE_ALLOC :
					(roll < 52) ? alp_pkg::MODE_RENEW :
					(roll < 67) ? alp_pkg::MODE_RELEASE :
					(roll < 77) ? alp_pkg::MODE_DECLINE :
					(roll < 92) ? alp_pkg::MODE_SWEEP :
					alp_pkg::mode_t'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));
			wall_clock += $urandom_range(0, stride);
			if (jumpy && $urandom_range(0, 9) == 0)
				wall_clock = $urandom();
			issue_request(op, ($urandom_range(0, 3) == 0) ? $urandom() : pick_address(),
				wall_clock, 1'b0, QUIET_ANSWER);
			seen++;
			if (op <= alp_pkg::MODE_SWEEP)
				counted++;
		end
	endtask

	// Reply checker and receiver stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_answers.size() == 0) begin
					flag_mismatch("reply with no request pending", {30'd0, reply}, 32'd0);
				end else begin
					head_answer = pending_answers.pop_front();
					if (reply !== head_answer.reply)
						flag_mismatch("reply", {30'd0, reply}, {30'd0, head_answer.reply});
					if (granted_address !== head_answer.granted)
						flag_mismatch("granted_address", granted_address, head_answer.granted);
					if (expired_count !== head_answer.expired)
						flag_mismatch("expired_count", {25'd0, expired_count},
							{25'd0, head_answer.expired});
					checked++;
					offers        += (head_answer.reply == alp_pkg::REPLY_OFFER);
					naks          += (head_answer.reply == alp_pkg::REPLY_NAK);
					expired_total += head_answer.expired;
				end
			end
			// Stalls start rarely and only while calm is clear.
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 1) begin
				stall_left = $urandom_range(0, 14);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#8_000_000;
		$display("address_lease_pool_top verification failed");
		$finish;
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		mode        = alp_pkg::MODE_ALLOC;
		address     = 32'd0;
		now_seconds = 32'd0;
		out_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = alp_pkg::CFG_BASE_ADDRESS;
		cfg_data    = 32'd0;
		calm          = 1'b0;
		stall_left    = 0;
		mismatches    = 0;
		accepted      = 0;
		checked       = 0;
		offers        = 0;
		naks          = 0;
		expired_total = 0;
		pool_settings = 1;
		wall_clock    = 32'd500;

		// Predicted pool after reset: every entry free, registers at their defaults.
		foreach (slot_free[i]) begin
			slot_free[i]  = 1'b1;
			slot_since[i] = 32'd0;
			slot_span[i]  = 32'd0;
		end
		next_fit  = 0;
		pool_base = RESET_BASE;
		lease_len = RESET_LEASE;

		// Directed script under the reset settings.
		script = '{
			'{alp_pkg::MODE_RENEW,   RESET_BASE,      32'd0,          1'b1,
				'{alp_pkg::REPLY_NAK, 32'd0, 7'd0}},
			'{alp_pkg::MODE_SWEEP,   32'd0,           32'd0,          1'b1, QUIET_ANSWER},
			'{alp_pkg::MODE_ALLOC,   32'hFFFF_FFFF,   32'd100,        1'b1,
				'{alp_pkg::REPLY_OFFER, RESET_BASE, 7'd0}},
			'{alp_pkg::MODE_ALLOC,   32'd0,           32'hFFFF_FFFF,  1'b1,
				'{alp_pkg::REPLY_OFFER, RESET_BASE + 32'd1, 7'd0}},
			'{alp_pkg::MODE_RENEW,   RESET_BASE,      32'd200,        1'b1,
				'{alp_pkg::REPLY_ACK, RESET_BASE, 7'd0}},
			// Addresses one below and one past the pool match nothing.
			'{alp_pkg::MODE_RENEW,   RESET_BASE - 1,  32'd200,        1'b1,
				'{alp_pkg::REPLY_NAK, 32'd0, 7'd0}},
			'{alp_pkg::MODE_RENEW,   RESET_BASE + 64, 32'd200,        1'b1,
				'{alp_pkg::REPLY_NAK, 32'd0, 7'd0}},
			'{alp_pkg::MODE_RELEASE, RESET_BASE + 1,  32'd210,        1'b1, QUIET_ANSWER},
			'{alp_pkg::MODE_RENEW,   RESET_BASE + 1,  32'd220,        1'b1,
				'{alp_pkg::REPLY_NAK, 32'd0, 7'd0}},
			'{alp_pkg::MODE_DECLINE, RESET_BASE + 5,  32'd230,        1'b1, QUIET_ANSWER},
			'{alp_pkg::MODE_RELEASE, 32'd0,           32'd240,        1'b1, QUIET_ANSWER},
			'{alp_pkg::MODE_DECLINE, 32'hFFFF_FFFF,   32'd240,        1'b1, QUIET_ANSWER},
			'{MODE_SPARE_A,          32'hFFFF_FFFF,   32'hFFFF_FFFF,  1'b1, QUIET_ANSWER},
			'{MODE_SPARE_B,          32'd0,           32'd0,          1'b1, QUIET_ANSWER},
			'{MODE_SPARE_C,          RESET_BASE,      32'd0,          1'b1, QUIET_ANSWER},
			// Declined entry keeps a zero-length lease and frees on this sweep.
			'{alp_pkg::MODE_SWEEP,   32'd0,           32'd250,        1'b0, QUIET_ANSWER},
			'{alp_pkg::MODE_ALLOC,   32'd0,           32'd260,        1'b0, QUIET_ANSWER},
			'{alp_pkg::MODE_ALLOC,   32'd0,           32'd260,        1'b0, QUIET_ANSWER},
			// One second short of the lease, then exactly at it.
			'{alp_pkg::MODE_SWEEP,   32'd0,           32'd499,        1'b0, QUIET_ANSWER},
			'{alp_pkg::MODE_SWEEP,   32'd0,           32'd500,        1'b0, QUIET_ANSWER},
			'{alp_pkg::MODE_ALLOC,   32'd0,           32'hFFFF_FF00,  1'b0, QUIET_ANSWER},
			// Time counter wraps between lease start and sweep.
			'{alp_pkg::MODE_SWEEP,   32'd0,           32'h0000_0100,  1'b0, QUIET_ANSWER},
			'{alp_pkg::MODE_RENEW,   RESET_BASE + 2,  32'hFFFF_FFFF,  1'b0, QUIET_ANSWER},
			'{alp_pkg::MODE_DECLINE, RESET_BASE + 63, 32'd300,        1'b1, QUIET_ANSWER},
			'{alp_pkg::MODE_RENEW,   RESET_BASE + 63, 32'd300,        1'b1,
				'{alp_pkg::REPLY_ACK, RESET_BASE + 32'd63, 7'd0}}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			issue_request(script[i].op, script[i].addr, script[i].stamp,
				script[i].typed, script[i].want);
		settle();

		// Random phases, each under its own pool settings.
		run_random_phase(250, 30, 1'b0);
		settle();

		set_pool_config(32'd0, 31'd0);
		run_random_phase(250, 5, 1'b0);
		settle();

		// Long stretch with neither side idling.
		calm = 1'b1;
		set_pool_config(32'hFFFF_FFFF, 31'h7FFF_FFFF);
		run_random_phase(250, 1000, 1'b1);
		settle();
		calm = 1'b0;

		set_pool_config(32'hFFFF_FFE0, 31'd1000);
		run_random_phase(250, 100, 1'b1);
		settle();

		set_pool_config($urandom(), 31'($urandom_range(1, 200)));
		run_random_phase(250, 20, 1'b0);
		settle();

		$display("Ran %0d requests, a directed table then random phases, under %0d pool settings;",
			accepted, pool_settings);
		$display("checked %0d replies: %0d offers, %0d naks, %0d leases reclaimed by sweeps.",
			checked, offers, naks, expired_total);
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("address_lease_pool_top verification clean");
		end else begin
			$display("address_lease_pool_top verification failed");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/alp_pkg.sv
hw/rtl/alp_ctrl.sv
hw/rtl/alp_dp.sv
hw/rtl/address_lease_pool_top.sv
test/address_lease_pool_top_tb.sv
